@@ sv/log_polynomial_potential_eval_top_macros.svh @@
// Assertion macros shared by the potential evaluator RTL.
`ifndef LOG_POLYNOMIAL_POTENTIAL_EVAL_TOP_MACROS_SVH
`define LOG_POLYNOMIAL_POTENTIAL_EVAL_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define LPPE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

`define LPPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define LPPE_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define LPPE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/lppe_pkg.sv @@
// Types and constants of the log-polynomial potential evaluator.
`default_nettype none

package lppe_pkg;

   localparam int U_W        = 32;
   localparam int COEF_W     = 32;
   localparam int OUT_W      = 48;
   localparam int NCOEF      = 8;
   localparam int COEF_IDX_W = 3;
   localparam int CSR_IDX_W  = 8;
   localparam int P_W        = 5;
   localparam int LOG_STAGES = 32;
   localparam int NL_W       = 31;
   localparam int LP_W       = 38;
   localparam int A_W        = 40;
   localparam int CW         = 44;
   localparam int TW         = 56;
   localparam int SW         = 58;
   localparam int NTERM      = 13;
   localparam int NPOW       = 6;
   localparam int MUL_LAT    = 3;
   localparam int LOG_SHIFT  = 26;
   localparam int TERM_SHIFT = 23;
   localparam int FRAC_SHIFT = 8;

   localparam logic [U_W-1:0] U_ONE   = 32'h8000_0000;
   localparam logic [U_W-1:0] LN2_Q32 = 32'd2977044472;

   localparam logic [COEF_IDX_W-1:0] COEF_A0  = 3'd0;
   localparam logic [COEF_IDX_W-1:0] COEF_A1  = 3'd1;
   localparam logic [COEF_IDX_W-1:0] COEF_A3  = 3'd2;
   localparam logic [COEF_IDX_W-1:0] COEF_A4  = 3'd3;
   localparam logic [COEF_IDX_W-1:0] COEF_A5C = 3'd4;
   localparam logic [COEF_IDX_W-1:0] COEF_A5L = 3'd5;
   localparam logic [COEF_IDX_W-1:0] COEF_A6C = 3'd6;
   localparam logic [COEF_IDX_W-1:0] COEF_A6L = 3'd7;

   typedef logic [NCOEF-1:0][COEF_W-1:0] coef_set_type;

   localparam coef_set_type COEF_RESET = {
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0000, 32'hFE00_0000, 32'h0100_0000
   };

   typedef struct packed {
      logic [U_W-1:0] x;
      logic [P_W-1:0] p;
      logic [U_W-1:0] m;
   } norm_item_type;

endpackage

`default_nettype wire

@@ sv/lppe_front.sv @@
// Input front end: clamps u and normalizes it for the logarithm.
`default_nettype none

module lppe_front import lppe_pkg::*; (
   input  logic [U_W-1:0] u_value,
   output norm_item_type  item
);

   logic [U_W-1:0] x;
   logic [P_W-1:0] p;

   always_comb begin
      x = u_value;
      if (u_value == '0) begin
         x = U_W'(1);
      end else if (u_value > U_ONE) begin
         x = U_ONE;
      end
      p = '0;
      for (int i = 0; i < U_W; i++) begin
         if (x[i]) begin
            p = P_W'(i);
         end
      end
      item.x = x;
      item.p = p;
      item.m = x << (P_W'(U_W - 1) - p);
   end

endmodule

`default_nettype wire

@@ sv/lppe_queue.sv @@
// Short queue of normalized transactions between front end and datapath.
`default_nettype none
`include "log_polynomial_potential_eval_top_macros.svh"

module lppe_queue import lppe_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  norm_item_type push_item,
   output logic          full,
   input  logic          pop,
   output norm_item_type pop_item,
   output logic          empty
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   norm_item_type   mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   `LPPE_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff <= CNTW'(DEPTH))
   `LPPE_ASSERT_NEXT(a_push_count, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1)
   `LPPE_ASSERT_IMPLY(a_empty_ptrs, clock, reset, count_ff == '0, rd_ff == wr_ff)

endmodule

`default_nettype wire

@@ sv/lppe_mulshr.sv @@
// Pipelined signed coefficient times unsigned power, shifted and truncated toward zero.
`default_nettype none

module lppe_mulshr import lppe_pkg::*; (
   input  logic                 clock,
   input  logic                 adv,
   input  logic signed [CW-1:0] coef,
   input  logic [U_W-1:0]       b,
   output logic signed [TW-1:0] res
);

   localparam int HW = CW / 2;
   localparam int PW = HW + U_W;
   localparam int FW = CW + U_W + 1;

   logic          neg1_ff, neg2_ff;
   logic [CW-1:0] mag_ff;
   logic [U_W-1:0] b_ff;
   logic [PW-1:0] pl_ff, ph_ff;
   logic [FW-1:0] full_in;
   logic [TW-1:0] rm_in, res_in;
   logic [TW-1:0] res_ff;

   assign full_in = (FW'(ph_ff) << HW) + FW'(pl_ff);
   assign rm_in   = TW'(full_in >> TERM_SHIFT);
   assign res_in  = neg2_ff ? (~rm_in + 1'b1) : rm_in;
   assign res     = signed'(res_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         neg1_ff <= coef[CW-1];
         mag_ff  <= coef[CW-1] ? (~coef + 1'b1) : coef;
         b_ff    <= b;
         neg2_ff <= neg1_ff;
         pl_ff   <= mag_ff[HW-1:0] * b_ff;
         ph_ff   <= mag_ff[CW-1:HW] * b_ff;
         res_ff  <= res_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/lppe_back.sv @@
// Evaluation datapath: logarithm, powers, coefficient terms, sums and saturation.
`default_nettype none
`include "log_polynomial_potential_eval_top_macros.svh"

module lppe_back import lppe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  coef_set_type          coef,
   input  norm_item_type         q_item,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  empty,
   input  logic                  pop,
   output logic signed [OUT_W-1:0] potential,
   output logic signed [OUT_W-1:0] first_derivative,
   output logic signed [OUT_W-1:0] second_derivative,
   output logic                  saturated
);

   localparam int ST_N5  = LOG_STAGES + 5;
   localparam int ST_SUM = ST_N5 + MUL_LAT + 1;
   localparam int NV     = ST_SUM + 1;
   localparam int N1_W   = U_W + P_W;

   localparam int TERM_POW [NTERM] = '{1, 3, 4, 5, 6, 2, 3, 4, 5, 1, 2, 3, 4};

   localparam logic signed [SW-1:0] OMAX =
      signed'({{(SW - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}});
   localparam logic signed [SW-1:0] OMIN =
      signed'({{(SW - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}});

   function automatic logic [LP_W-1:0] log_prod(logic [COEF_W-1:0] c, logic [NL_W-1:0] n);
      logic [COEF_W-1:0]      mag;
      logic [COEF_W+NL_W-1:0] pr;
      logic [LP_W-1:0]        r;
      mag = c[COEF_W-1] ? (~c + 1'b1) : c;
      pr  = mag * n;
      r   = LP_W'(pr >> LOG_SHIFT);
      return c[COEF_W-1] ? (~r + 1'b1) : r;
   endfunction

   function automatic logic [OUT_W:0] clip(logic signed [SW-1:0] v);
      logic [OUT_W:0] r;
      if (v > OMAX) begin
         r = {1'b1, OMAX[OUT_W-1:0]};
      end else if (v < OMIN) begin
         r = {1'b1, OMIN[OUT_W-1:0]};
      end else begin
         r = {1'b0, v[OUT_W-1:0]};
      end
      return r;
   endfunction

   logic             adv;
   logic [NV-1:0]    v_ff;
   logic             out_v_ff;

   logic [U_W-1:0]   m_ff  [0:LOG_STAGES];
   logic [U_W-1:0]   f_ff  [0:LOG_STAGES];
   logic [P_W-1:0]   p_ff  [0:LOG_STAGES];
   logic [U_W-1:0]   pw_ff [0:ST_N5][1:NPOW];

   logic [N1_W-1:0]  n1_ff;
   logic [U_W-1:0]   fl_ff;
   logic [2*U_W-1:0] fp_in;
   logic [N1_W-1:0]  diff_in;
   logic [NL_W-1:0]  nl_ff;
   logic [LP_W-1:0]  lp5_ff, lp6_ff;
   logic signed [A_W-1:0] a5_ff, a6_ff;

   logic signed [CW-1:0] c_a1, c_a3, c_a4, c_a5l, c_a6l, a5e, a6e;
   logic signed [CW-1:0] cf_in [NTERM];
   logic signed [CW-1:0] cf_ff [NTERM];
   logic signed [TW-1:0] tm [NTERM];

   logic signed [SW-1:0] a0t, a1t;
   logic signed [SW-1:0] pa_ff, pb_ff, da_ff, db_ff, ea_ff, eb_ff;
   logic [OUT_W:0]       cp_in, cd1_in, cd2_in;
   logic [OUT_W-1:0]     pot_ff, d1_ff, d2_ff;
   logic                 sat_ff;

   assign adv   = !out_v_ff || pop;
   assign q_pop = adv && !q_empty;
   assign empty = !out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff     <= {v_ff[NV-2:0], !q_empty};
         out_v_ff <= v_ff[NV-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff[0] <= q_item.m;
         f_ff[0] <= '0;
         p_ff[0] <= q_item.p;
         for (int k = 1; k <= NPOW; k++) begin
            pw_ff[0][k] <= q_item.x;
         end
      end
   end

   for (genvar i = 1; i <= LOG_STAGES; i++) begin : g_log
      logic [2*U_W-1:0] sq_in;
      logic [U_W:0]     t_in;
      logic [U_W-1:0]   m_in, f_in;
      assign sq_in = m_ff[i-1] * m_ff[i-1];
      assign t_in  = sq_in[2*U_W-1:U_W-1];
      assign m_in  = t_in[U_W] ? t_in[U_W:1] : t_in[U_W-1:0];
      assign f_in  = f_ff[i-1] | (U_W'(t_in[U_W]) << (U_W - i));
      always_ff @(posedge clock) begin
         if (adv) begin
            m_ff[i] <= m_in;
            f_ff[i] <= f_in;
            p_ff[i] <= p_ff[i-1];
         end
      end
   end

   for (genvar i = 1; i <= ST_N5; i++) begin : g_pw
      for (genvar k = 1; k <= NPOW; k++) begin : g_k
         if (k == i + 1) begin : g_mul
            logic [2*U_W-1:0] pr_in;
            assign pr_in = pw_ff[i-1][k-1] * pw_ff[i-1][1];
            always_ff @(posedge clock) begin
               if (adv) begin
                  pw_ff[i][k] <= pr_in[2*U_W-2:U_W-1];
               end
            end
         end else begin : g_cp
            always_ff @(posedge clock) begin
               if (adv) begin
                  pw_ff[i][k] <= pw_ff[i-1][k];
               end
            end
         end
      end
   end

   assign fp_in   = f_ff[LOG_STAGES] * LN2_Q32;
   assign diff_in = n1_ff - N1_W'(fl_ff);

   assign c_a1  = CW'(signed'(coef[COEF_A1]));
   assign c_a3  = CW'(signed'(coef[COEF_A3]));
   assign c_a4  = CW'(signed'(coef[COEF_A4]));
   assign c_a5l = CW'(signed'(coef[COEF_A5L]));
   assign c_a6l = CW'(signed'(coef[COEF_A6L]));
   assign a5e   = CW'(a5_ff);
   assign a6e   = CW'(a6_ff);

   always_comb begin
      cf_in[0]  = c_a1;
      cf_in[1]  = c_a3;
      cf_in[2]  = c_a4;
      cf_in[3]  = a5e;
      cf_in[4]  = a6e;
      cf_in[5]  = c_a3 * CW'(3);
      cf_in[6]  = c_a4 * CW'(4);
      cf_in[7]  = a5e * CW'(5) + c_a5l;
      cf_in[8]  = a6e * CW'(6) + c_a6l;
      cf_in[9]  = c_a3 * CW'(6);
      cf_in[10] = c_a4 * CW'(12);
      cf_in[11] = a5e * CW'(20) + c_a5l * CW'(9);
      cf_in[12] = a6e * CW'(30) + c_a6l * CW'(11);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_ff  <= N1_W'(P_W'(U_W - 1) - p_ff[LOG_STAGES]) * N1_W'(LN2_Q32);
         fl_ff  <= fp_in[2*U_W-1:U_W];
         nl_ff  <= diff_in[N1_W-1:N1_W-NL_W];
         lp5_ff <= log_prod(coef[COEF_A5L], nl_ff);
         lp6_ff <= log_prod(coef[COEF_A6L], nl_ff);
         a5_ff  <= A_W'(signed'(coef[COEF_A5C])) - A_W'(signed'(lp5_ff));
         a6_ff  <= A_W'(signed'(coef[COEF_A6C])) - A_W'(signed'(lp6_ff));
         for (int j = 0; j < NTERM; j++) begin
            cf_ff[j] <= cf_in[j];
         end
      end
   end

   for (genvar j = 0; j < NTERM; j++) begin : g_term
      lppe_mulshr u_mul (
         .clock (clock),
         .adv   (adv),
         .coef  (cf_ff[j]),
         .b     (pw_ff[ST_N5][TERM_POW[j]]),
         .res   (tm[j])
      );
   end

   assign a0t = SW'(signed'(coef[COEF_A0])) <<< FRAC_SHIFT;
   assign a1t = SW'(signed'(coef[COEF_A1])) <<< FRAC_SHIFT;

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff <= a0t + SW'(tm[0]) + SW'(tm[1]);
         pb_ff <= SW'(tm[2]) + SW'(tm[3]) + SW'(tm[4]);
         da_ff <= a1t + SW'(tm[5]) + SW'(tm[6]);
         db_ff <= SW'(tm[7]) + SW'(tm[8]);
         ea_ff <= SW'(tm[9]) + SW'(tm[10]);
         eb_ff <= SW'(tm[11]) + SW'(tm[12]);
      end
   end

   assign cp_in  = clip(pa_ff + pb_ff);
   assign cd1_in = clip(da_ff + db_ff);
   assign cd2_in = clip(ea_ff + eb_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         pot_ff <= cp_in[OUT_W-1:0];
         d1_ff  <= cd1_in[OUT_W-1:0];
         d2_ff  <= cd2_in[OUT_W-1:0];
         sat_ff <= cp_in[OUT_W] | cd1_in[OUT_W] | cd2_in[OUT_W];
      end
   end

   assign potential         = signed'(pot_ff);
   assign first_derivative  = signed'(d1_ff);
   assign second_derivative = signed'(d2_ff);
   assign saturated         = sat_ff;

   `LPPE_ASSERT_NEXT(a_stall_holds, clock, reset, !adv, $stable(v_ff))
   `LPPE_ASSERT_NEXT(a_out_load, clock, reset, adv && v_ff[NV-1], out_v_ff)
   `LPPE_ASSERT_NEXT(a_out_kept, clock, reset, out_v_ff && !pop, out_v_ff && $stable(pot_ff))

endmodule

`default_nettype wire

@@ sv/log_polynomial_potential_eval_top.sv @@
// Top level of the log-polynomial potential evaluator.
//
// channel   direction  handshake               payload
// input     in         push / full             req_u_value
// result    out        empty / pop             rsp_potential, rsp_first_derivative,
//                                              rsp_second_derivative, rsp_saturated
// csr       in         csr_valid / csr_ready   csr_index, csr_data
//
// One transaction per cycle sustained while results are popped; every datapath stage holds one transaction.
// From acceptance to result a transaction passes the 32-stage squaring chain
// of the logarithm, the 3-stage term multipliers and the sum and saturate stages.
// The datapath advances as a whole when the result register is empty or popped;
// while it stalls the input queue keeps taking transactions until it fills.
// Synchronous reset empties queue and pipeline and restores the coefficients.
`default_nettype none

module log_polynomial_potential_eval_top import lppe_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [U_W-1:0]          req_u_value,
   output logic                    empty,
   input  logic                    pop,
   output logic signed [OUT_W-1:0] rsp_potential,
   output logic signed [OUT_W-1:0] rsp_first_derivative,
   output logic signed [OUT_W-1:0] rsp_second_derivative,
   output logic                    rsp_saturated,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [COEF_W-1:0]       csr_data
);

   coef_set_type  coef_ff;
   norm_item_type fr_item, q_item;
   logic          q_full, q_empty, q_pop;

   assign csr_ready = 1'b1;
   assign full      = q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(NCOEF))) begin
         coef_ff[csr_index[COEF_IDX_W-1:0]] <= csr_data;
      end
   end

   lppe_front u_front (
      .u_value (req_u_value),
      .item    (fr_item)
   );

   lppe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (fr_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   lppe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .coef              (coef_ff),
      .q_item            (q_item),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .empty             (empty),
      .pop               (pop),
      .potential         (rsp_potential),
      .first_derivative  (rsp_first_derivative),
      .second_derivative (rsp_second_derivative),
      .saturated         (rsp_saturated)
   );

endmodule

`default_nettype wire

@@ dv/tb_log_polynomial_potential_eval_top.sv @@
// Self-checking testbench for the log-polynomial potential evaluator top level.
`timescale 1ns / 1ps
`default_nettype none

module tb_log_polynomial_potential_eval_top;
   import lppe_pkg::*;

   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_LIMIT  = 4000;
   localparam int NPHASE       = 6;
   localparam int PHASE_ITEMS  = 195;

   typedef struct {
      logic [OUT_W-1:0] pot;
      logic [OUT_W-1:0] d1;
      logic [OUT_W-1:0] d2;
      logic             sat;
   } potential_result_type;

   logic                    clock;
   logic                    reset;
   logic                    push;
   logic                    full;
   logic [U_W-1:0]          req_u_value;
   logic                    empty;
   logic                    pop;
   logic signed [OUT_W-1:0] rsp_potential;
   logic signed [OUT_W-1:0] rsp_first_derivative;
   logic signed [OUT_W-1:0] rsp_second_derivative;
   logic                    rsp_saturated;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [COEF_W-1:0]       csr_data;

   logic [U_W-1:0]       pending_u[$];
   potential_result_type expected_results[$];
   longint               coef_model[NCOEF];
   int                   send_idle_pct;
   int                   recv_idle_pct;
   int                   mismatch_count;
   int                   stall_cycles;

   log_polynomial_potential_eval_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_u_value          (req_u_value),
      .empty                (empty),
      .pop                  (pop),
      .rsp_potential        (rsp_potential),
      .rsp_first_derivative (rsp_first_derivative),
      .rsp_second_derivative(rsp_second_derivative),
      .rsp_saturated        (rsp_saturated),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // signed coefficient times unsigned value, shifted, truncated toward zero
   function automatic longint scaled_product(longint c, bit [63:0] b, int s);
      bit [63:0] mag;
      bit [63:0] mask;
      bit [63:0] r;
      mag  = (c < 0) ? 64'(-c) : 64'(c);
      mask = (64'd1 << s) - 64'd1;
      r    = (mag >> s) * b + (((mag & mask) * b) >> s);
      return (c < 0) ? -longint'(r) : longint'(r);
   endfunction

   // -ln(x * 2^-31) in Q.26
   function automatic bit [63:0] neg_log_q26(bit [31:0] x);
      int        p;
      bit [63:0] m;
      bit [63:0] f;
      bit [63:0] n;
      p = 0;
      f = 0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) p = i;
      end
      m = 64'(x) << (31 - p);
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            f[31-i] = 1'b1;
            m = m >> 1;
         end
      end
      n = 64'(31 - p) * 64'(LN2_Q32) - ((f * 64'(LN2_Q32)) >> 32);
      return n >> 6;
   endfunction

   function automatic logic [OUT_W-1:0] clip_q16_32(longint v, ref logic sat);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (OUT_W - 1)) - 1;
      lo = -(64'sd1 <<< (OUT_W - 1));
      if (v > hi) begin
         v = hi;
         sat = 1'b1;
      end
      if (v < lo) begin
         v = lo;
         sat = 1'b1;
      end
      return v[OUT_W-1:0];
   endfunction

   function automatic potential_result_type eval_potential(logic [U_W-1:0] u_in);
      bit [63:0] x;
      bit [63:0] u1, u2, u3, u4, u5, u6, nl;
      longint a0, a1, a3, a4, a5l, a6l, a5, a6, pot, d1, d2;
      potential_result_type r;
      logic sat;
      x = 64'(u_in);
      if (x == 0) x = 1;
      if (x > 64'(U_ONE)) x = 64'(U_ONE);
      u1 = x;
      u2 = (u1 * u1) >> 31;
      u3 = (u2 * u1) >> 31;
      u4 = (u3 * u1) >> 31;
      u5 = (u4 * u1) >> 31;
      u6 = (u5 * u1) >> 31;
      a0  = coef_model[COEF_A0];
      a1  = coef_model[COEF_A1];
      a3  = coef_model[COEF_A3];
      a4  = coef_model[COEF_A4];
      a5l = coef_model[COEF_A5L];
      a6l = coef_model[COEF_A6L];
      nl  = neg_log_q26(x[31:0]);
      a5  = coef_model[COEF_A5C] - scaled_product(a5l, nl, LOG_SHIFT);
      a6  = coef_model[COEF_A6C] - scaled_product(a6l, nl, LOG_SHIFT);
      pot = a0 * 256 + scaled_product(a1, u1, TERM_SHIFT)
          + scaled_product(a3, u3, TERM_SHIFT) + scaled_product(a4, u4, TERM_SHIFT)
          + scaled_product(a5, u5, TERM_SHIFT) + scaled_product(a6, u6, TERM_SHIFT);
      d1  = a1 * 256 + scaled_product(3 * a3, u2, TERM_SHIFT)
          + scaled_product(4 * a4, u3, TERM_SHIFT)
          + scaled_product(5 * a5 + a5l, u4, TERM_SHIFT)
          + scaled_product(6 * a6 + a6l, u5, TERM_SHIFT);
      d2  = scaled_product(6 * a3, u1, TERM_SHIFT)
          + scaled_product(12 * a4, u2, TERM_SHIFT)
          + scaled_product(20 * a5 + 9 * a5l, u3, TERM_SHIFT)
          + scaled_product(30 * a6 + 11 * a6l, u4, TERM_SHIFT);
      sat   = 1'b0;
      r.pot = clip_q16_32(pot, sat);
      r.d1  = clip_q16_32(d1, sat);
      r.d2  = clip_q16_32(d2, sat);
      r.sat = sat;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            expected_results.push_back(eval_potential(req_u_value));
            void'(pending_u.pop_front());
         end
         if (pending_u.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            push        <= 1'b1;
            req_u_value <= pending_u[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      potential_result_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected", 64'(rsp_potential), 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_potential !== want.pot)
                  report_mismatch("potential", 64'(rsp_potential), 64'(want.pot));
               if (rsp_first_derivative !== want.d1)
                  report_mismatch("first_derivative", 64'(rsp_first_derivative),
                                  64'(want.d1));
               if (rsp_second_derivative !== want.d2)
                  report_mismatch("second_derivative", 64'(rsp_second_derivative),
                                  64'(want.d2));
               if (rsp_saturated !== want.sat)
                  report_mismatch("saturated", 64'(rsp_saturated), 64'(want.sat));
            end
         end
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_coef(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx < NCOEF) coef_model[idx[COEF_IDX_W-1:0]] = longint'(signed'(value));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_u.size() != 0 || expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [U_W-1:0] random_u();
      int kind;
      kind = $urandom_range(9);
      if (kind < 6) return $urandom_range(32'(U_ONE), 1);
      if (kind < 8) return $urandom_range((32'd1 << $urandom_range(31)), 1);
      if (kind < 9) return 32'(U_ONE) - $urandom_range(4096);
      return $urandom;
   endfunction

   function automatic logic [COEF_W-1:0] phase_coef(int phase);
      case (phase)
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return $urandom;
         default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
      endcase
   endfunction

   initial begin
      logic [U_W-1:0] directed_u[$];
      directed_u = '{32'd0, 32'd1, 32'd2, 32'd3, 32'h8000_0000, 32'h8000_0001,
                     32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'h0000_FFFF, 32'h0001_0000};
      reset          = 1'b1;
      push           = 1'b0;
      pop            = 1'b0;
      req_u_value    = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      mismatch_count = 0;
      stall_cycles   = 0;
      send_idle_pct  = 29;
      recv_idle_pct  = 52;
      for (int i = 0; i < NCOEF; i++) coef_model[i] = longint'(signed'(COEF_RESET[i]));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < NPHASE; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 52;
            recv_idle_pct = 29;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase > 0) begin
            for (int i = 0; i < NCOEF; i++) write_coef(CSR_IDX_W'(i), phase_coef(phase));
            write_coef(CSR_IDX_W'($urandom_range(255, NCOEF)), $urandom);
         end
         foreach (directed_u[i]) pending_u.push_back(directed_u[i]);
         for (int i = 0; i < PHASE_ITEMS; i++) pending_u.push_back(random_u());
         wait_idle();
      end
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
